@@ hdl/acir_pkg.sv @@
// Shared types and constants for the air-conditioner infrared frame encoder.
package acir_pkg;

  // Request operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NEXT = 1'b1
  } op_t;

  // Timing register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ONE_SPACE    = 3'd3,
    REG_ZERO_SPACE   = 3'd4,
    REG_GAP_SPACE    = 3'd5
  } reg_idx_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned DUR_W       = 16;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned FRAME_W     = 64;

  typedef struct packed {
    logic [DUR_W-1:0] header_mark_us;
    logic [DUR_W-1:0] header_space_us;
    logic [DUR_W-1:0] bit_mark_us;
    logic [DUR_W-1:0] one_space_us;
    logic [DUR_W-1:0] zero_space_us;
    logic [DUR_W-1:0] gap_space_us;
  } cfg_t;

  // Timing reset values in microseconds
  localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd9000;
  localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4500;
  localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd620;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1600;
  localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd540;
  localparam logic [DUR_W-1:0] RST_GAP_SPACE    = 16'd19980;

  // Frame content
  localparam logic [2:0] MODE_MAX   = 3'd4;
  localparam logic [7:0] TEMP_MIN   = 8'd16;
  localparam logic [7:0] TEMP_MAX   = 8'd30;
  localparam logic [7:0] BYTE2      = 8'h20;
  localparam logic [7:0] BYTE3      = 8'h50;
  localparam logic [7:0] BYTE4      = 8'h00;
  localparam logic [7:0] BYTE5      = 8'h20;
  localparam logic [7:0] BYTE6      = 8'h00;
  localparam logic [3:0] CHECK_BASE = 4'd10;
  localparam logic [2:0] FOOTER     = 3'b010;

  // Pulse positions within a frame
  localparam logic [POS_W-1:0] POS_HEADER_SPACE = 8'd1;
  localparam logic [POS_W-1:0] POS_LOW_START    = 8'd2;
  localparam logic [POS_W-1:0] POS_FOOTER_START = 8'd66;
  localparam logic [POS_W-1:0] POS_FOOTER_END   = 8'd72;
  localparam logic [POS_W-1:0] POS_MID_GAP      = 8'd73;
  localparam logic [POS_W-1:0] POS_HIGH_START   = 8'd74;
  localparam logic [POS_W-1:0] POS_TAIL         = 8'd138;
  localparam logic [POS_W-1:0] POS_LAST         = 8'd139;

endpackage

@@ hdl/acir_cfg_regs.sv @@
// Timing register file written through the configuration port.
module acir_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [acir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [acir_pkg::DUR_W-1:0]       cfg_data,
  output acir_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_mark_us  <= acir_pkg::RST_HEADER_MARK;
      cfg.header_space_us <= acir_pkg::RST_HEADER_SPACE;
      cfg.bit_mark_us     <= acir_pkg::RST_BIT_MARK;
      cfg.one_space_us    <= acir_pkg::RST_ONE_SPACE;
      cfg.zero_space_us   <= acir_pkg::RST_ZERO_SPACE;
      cfg.gap_space_us    <= acir_pkg::RST_GAP_SPACE;
    end else if (cfg_write) begin
      case (cfg_index)
        acir_pkg::REG_HEADER_MARK:  cfg.header_mark_us  <= cfg_data;
        acir_pkg::REG_HEADER_SPACE: cfg.header_space_us <= cfg_data;
        acir_pkg::REG_BIT_MARK:     cfg.bit_mark_us     <= cfg_data;
        acir_pkg::REG_ONE_SPACE:    cfg.one_space_us    <= cfg_data;
        acir_pkg::REG_ZERO_SPACE:   cfg.zero_space_us   <= cfg_data;
        acir_pkg::REG_GAP_SPACE:    cfg.gap_space_us    <= cfg_data;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

endmodule

@@ hdl/acir_frame_pack.sv @@
// Packs unit settings into the 64-bit frame with its nibble checksum.
module acir_frame_pack (
  input  logic                          power_on,
  input  logic [2:0]                    mode_code,
  input  logic [1:0]                    fan_code,
  input  logic                          swing_on,
  input  logic [7:0]                    temp_celsius,
  output logic [acir_pkg::FRAME_W-1:0]  frame
);

  logic [2:0] mode_eff;
  logic [7:0] temp_clamped;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [3:0] checksum;

  assign mode_eff = (mode_code > acir_pkg::MODE_MAX) ? 3'd0 : mode_code;

  always_comb begin
    if (temp_celsius < acir_pkg::TEMP_MIN) begin
      temp_clamped = acir_pkg::TEMP_MIN;
    end else if (temp_celsius > acir_pkg::TEMP_MAX) begin
      temp_clamped = acir_pkg::TEMP_MAX;
    end else begin
      temp_clamped = temp_celsius;
    end
  end

  assign byte0 = {1'b0, swing_on, fan_code, power_on, mode_eff};
  assign byte1 = temp_clamped - acir_pkg::TEMP_MIN;

  // 4-bit sum wraps mod 16
  assign checksum = acir_pkg::CHECK_BASE + byte0[3:0] + byte1[3:0]
                  + acir_pkg::BYTE2[3:0] + acir_pkg::BYTE3[3:0]
                  + acir_pkg::BYTE4[7:4] + acir_pkg::BYTE5[7:4]
                  + acir_pkg::BYTE6[7:4];

  assign frame = {checksum, 4'h0, acir_pkg::BYTE6, acir_pkg::BYTE5, acir_pkg::BYTE4,
                  acir_pkg::BYTE3, acir_pkg::BYTE2, byte1, byte0};

endmodule

@@ hdl/acir_pulse_select.sv @@
// Picks the duration of one pulse from its frame position.
module acir_pulse_select (
  input  acir_pkg::cfg_t                cfg,
  input  logic [acir_pkg::FRAME_W-1:0]  frame,
  input  logic [acir_pkg::POS_W-1:0]    pos,
  output logic [acir_pkg::DUR_W-1:0]    duration
);

  logic [acir_pkg::POS_W-1:0] off_low;
  logic [acir_pkg::POS_W-1:0] off_footer;
  logic [acir_pkg::POS_W-1:0] off_high;
  logic [acir_pkg::DUR_W-1:0] space_low;
  logic [acir_pkg::DUR_W-1:0] space_footer;
  logic [acir_pkg::DUR_W-1:0] space_high;

  assign off_low    = pos - acir_pkg::POS_LOW_START;
  assign off_footer = pos - acir_pkg::POS_FOOTER_START;
  assign off_high   = pos - acir_pkg::POS_HIGH_START;

  // low half is bytes 0..3, high half bytes 4..7
  assign space_low    = frame[{1'b0, off_low[5:1]}] ? cfg.one_space_us : cfg.zero_space_us;
  assign space_footer = acir_pkg::FOOTER[off_footer[2:1]] ?
                        cfg.one_space_us : cfg.zero_space_us;
  assign space_high   = frame[{1'b1, off_high[5:1]}] ?
                        cfg.one_space_us : cfg.zero_space_us;

  always_comb begin
    if (pos == '0) begin
      duration = cfg.header_mark_us;
    end else if (pos == acir_pkg::POS_HEADER_SPACE) begin
      duration = cfg.header_space_us;
    end else if (!pos[0]) begin
      duration = cfg.bit_mark_us;
    end else if (pos < acir_pkg::POS_FOOTER_START) begin
      duration = space_low;
    end else if (pos < acir_pkg::POS_FOOTER_END) begin
      duration = space_footer;
    end else if (pos == acir_pkg::POS_MID_GAP) begin
      duration = cfg.gap_space_us;
    end else if (pos < acir_pkg::POS_TAIL) begin
      duration = space_high;
    end else begin
      duration = cfg.gap_space_us;
    end
  end

endmodule

@@ hdl/ac_ir_frame_encoder_unit.sv @@
// Top level of the air-conditioner infrared frame encoder.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  item     | item_valid / item_stall    | operation, power_on, mode_code, fan_code,
//           |                            | swing_on, temp_celsius
//  pulse    | pulse_valid / pulse_stall  | duration_us, is_mark, last_pulse
//  config   | cfg_write                  | cfg_index, cfg_data
//
// One request per cycle sustained while the pulse output is not stalled. A request sits
// in the input register; from there a load packs the frame into the frame state, and a
// next runs pulse selection in one pass into the result register.
// Synchronous rst clears handshake state and frame state and resets the timing registers to their defaults.
// A stalled result holds the input register; a load (no result) or a next with no
// frame armed never needs the output stage, but still waits behind a stalled result.
module ac_ir_frame_encoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  // request channel
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             operation,
  input  logic                             power_on,
  input  logic [2:0]                       mode_code,
  input  logic [1:0]                       fan_code,
  input  logic                             swing_on,
  input  logic [7:0]                       temp_celsius,
  // pulse channel
  output logic                             pulse_valid,
  input  logic                             pulse_stall,
  output logic [acir_pkg::DUR_W-1:0]       duration_us,
  output logic                             is_mark,
  output logic                             last_pulse,
  // configuration port
  input  logic                             cfg_write,
  input  logic [acir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [acir_pkg::DUR_W-1:0]       cfg_data
);

  acir_pkg::cfg_t cfg;

  // Input register
  logic        req_valid;
  logic        req_op;
  logic        req_power;
  logic [2:0]  req_mode;
  logic [1:0]  req_fan;
  logic        req_swing;
  logic [7:0]  req_temp;

  // Frame state
  logic [acir_pkg::FRAME_W-1:0] frame_bits;
  logic [acir_pkg::POS_W-1:0]   pulse_position;
  logic                         frame_active;

  logic [acir_pkg::FRAME_W-1:0] packed_frame;
  logic [acir_pkg::DUR_W-1:0]   sel_duration;
  logic                         req_go;
  logic                         do_load;
  logic                         do_pulse;
  logic                         at_last;

  acir_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  acir_frame_pack u_pack (
    .power_on     (req_power),
    .mode_code    (req_mode),
    .fan_code     (req_fan),
    .swing_on     (req_swing),
    .temp_celsius (req_temp),
    .frame        (packed_frame)
  );

  acir_pulse_select u_sel (
    .cfg      (cfg),
    .frame    (frame_bits),
    .pos      (pulse_position),
    .duration (sel_duration)
  );

  // Held request moves on when the result register is free or being emptied
  assign req_go     = req_valid && (!pulse_valid || !pulse_stall);
  assign item_stall = req_valid && !req_go;
  assign do_load    = req_go && (req_op == acir_pkg::OP_LOAD);
  assign do_pulse   = req_go && (req_op == acir_pkg::OP_NEXT) && frame_active;
  assign at_last    = (pulse_position == acir_pkg::POS_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      req_valid <= 1'b1;
    end else if (req_go) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      req_op    <= operation;
      req_power <= power_on;
      req_mode  <= mode_code;
      req_fan   <= fan_code;
      req_swing <= swing_on;
      req_temp  <= temp_celsius;
    end
  end

  // Frame state: a load restarts the frame, the last pulse disarms it
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits     <= '0;
      pulse_position <= '0;
      frame_active   <= 1'b0;
    end else if (do_load) begin
      frame_bits     <= packed_frame;
      pulse_position <= '0;
      frame_active   <= 1'b1;
    end else if (do_pulse) begin
      if (at_last) begin
        pulse_position <= '0;
        frame_active   <= 1'b0;
      end else begin
        pulse_position <= pulse_position + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_valid <= 1'b0;
    end else if (do_pulse) begin
      pulse_valid <= 1'b1;
    end else if (!pulse_stall) begin
      pulse_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pulse) begin
      duration_us <= sel_duration;
      is_mark     <= !pulse_position[0];
      last_pulse  <= at_last;
    end
  end

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pulse_position <= acir_pkg::POS_LAST)
    else $error("pulse position past end of frame");

  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !frame_active |-> pulse_position == '0)
    else $error("position not cleared while idle");

  a_load_arms: assert property (@(posedge clk) disable iff (rst)
    do_load |=> frame_active && pulse_position == '0)
    else $error("load did not arm frame");

  a_last_disarms: assert property (@(posedge clk) disable iff (rst)
    do_pulse && at_last |=> !frame_active && pulse_valid && last_pulse)
    else $error("last pulse did not close frame");

  a_last_is_space: assert property (@(posedge clk) disable iff (rst)
    pulse_valid && last_pulse |-> !is_mark)
    else $error("final pulse flagged as mark");

endmodule
